// ----- rtl/ctb_pkg.sv -----
// Package for the countdown timer bank: sizes, command codes and reset values.
// Used by countdown_timer_bank and its port checker; it depends on nothing else.
package ctb_pkg;

    localparam int NUM_TIMERS  = 6;
    localparam int COUNT_WIDTH = 15;

    localparam int CMD_W   = 2;
    localparam int SEL_W   = 3;
    localparam int LOAD_W  = 15;
    localparam int LIMIT_W = 15;
    localparam int FLAGS_W = 6;

    localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
    // Only the first six timers are visible in the result.
    localparam int OUT_TIMERS = (NUM_TIMERS < FLAGS_W) ? NUM_TIMERS : FLAGS_W;

    localparam int PHASE_IDX   = 0;
    localparam int DISPLAY_IDX = 3;

    localparam int S_TDATA_W = ((LOAD_W + 7) / 8) * 8;
    localparam int S_TUSER_W = CMD_W + SEL_W;
    localparam int M_TDATA_W = ((1 + FLAGS_W + 7) / 8) * 8;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_PHASE_LIMIT = '0;
    localparam logic [LIMIT_W-1:0] PHASE_LIMIT_RESET = LIMIT_W'(500);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_REARM = 2'd3
    } cmd_t;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    // Reset count of each timer: the valve timer starts at 500, the lcd timer at 300, all others at 1.
    function automatic count_t reset_count(input int idx);
        logic [31:0] val;
        begin
            val = 32'd1;
            if (idx == 2) begin
                val = 32'd500;
            end else if (idx == 4) begin
                val = 32'd300;
            end
            return count_t'(val);
        end
    endfunction

endpackage

// ----- rtl/countdown_timer_bank.sv -----
// Top level of the countdown timer bank: a two-register command pipeline with the
// timer state, plus an APB register for the phase limit. Depends on ctb_pkg.

// The bank holds six countdown timers, each with an event flag. Every command
// transaction on the s_axis channel (tick, set, clear, test-and-rearm) yields exactly
// one result transaction on m_axis carrying the prior flag of the selected timer and
// all six flags after the command. A command is taken into an input register, applied
// to the timer state while the result is written into the output register, which
// offers it on m_axis; while m_axis stalls, the command waits in the input register.
// One command is accepted every cycle; the only limit is m_axis_tready, since the
// output register frees its slot in the same cycle that its result is taken. A tick
// decrements every nonzero count and raises the flag of each expired timer (the breath
// display timer drops its flag instead), then clamps the phase timer to phase_limit.
// phase_limit sits at APB byte address 0 and resets to 500; it should only be written
// while no command is in flight.
module countdown_timer_bank (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Command channel
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ctb_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [14:0] load_ticks
    input  logic [ctb_pkg::S_TUSER_W-1:0] s_axis_tuser,  // [1:0] cmd, [4:2] timer_sel
    // Result channel
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ctb_pkg::M_TDATA_W-1:0] m_axis_tdata,  // [0] selected_flag, [6:1] all_flags
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ctb_pkg::PADDR_W-1:0]   paddr,
    input  logic [ctb_pkg::PDATA_W-1:0]   pwdata,
    output logic [ctb_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int N  = ctb_pkg::NUM_TIMERS;
    localparam int CW = ctb_pkg::COUNT_WIDTH;

    // Input register.
    logic                          in_valid_reg;
    ctb_pkg::cmd_t                 in_cmd_reg;
    logic [ctb_pkg::SEL_W-1:0]     in_sel_reg;
    logic [ctb_pkg::LOAD_W-1:0]    in_load_reg;

    // Output register.
    logic                          out_valid_reg;
    logic                          out_sel_flag_reg;
    logic [ctb_pkg::FLAGS_W-1:0]   out_flags_reg;

    // Timer state and configuration.
    ctb_pkg::count_t               counts_reg [N];
    ctb_pkg::count_t               counts_next [N];
    logic [N-1:0]                  flags_reg;
    logic [N-1:0]                  flags_next;
    logic [ctb_pkg::LIMIT_W-1:0]   phase_limit_reg;

    logic                          advance;
    logic                          cfg_write;
    logic                          sel_flag;
    logic [ctb_pkg::FLAGS_W-1:0]   flags_out;

    // The output register can take a new result when it is empty or being drained;
    // the input register moves on whenever that happens.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = ctb_pkg::M_TDATA_W'({out_flags_reg, out_sel_flag_reg});

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[ctb_pkg::PADDR_W-1:2] == ctb_pkg::REG_PHASE_LIMIT);
    assign prdata    = (paddr[ctb_pkg::PADDR_W-1:2] == ctb_pkg::REG_PHASE_LIMIT)
                       ? ctb_pkg::PDATA_W'(phase_limit_reg) : '0;

    // Apply the command in the input register to the timer state.
    always_comb begin
        logic hit;
        logic [ctb_pkg::CMP_W-1:0] phase_cnt;
        logic [ctb_pkg::CMP_W-1:0] phase_lim;
        counts_next = counts_reg;
        flags_next  = flags_reg;
        sel_flag    = 1'b0;
        flags_out   = '0;
        phase_cnt   = '0;
        phase_lim   = '0;
        hit         = 1'b0;

        // A selector past the last timer matches nothing and reads as a clear flag.
        for (int i = 0; i < N; i++) begin
            if (32'(in_sel_reg) == i) begin
                sel_flag = flags_reg[i];
            end
        end

        unique case (in_cmd_reg)
            ctb_pkg::CMD_TICK: begin
                for (int i = 0; i < N; i++) begin
                    if (counts_reg[i] == '0) begin
                        flags_next[i] = (i != ctb_pkg::DISPLAY_IDX);
                    end else begin
                        counts_next[i] = counts_reg[i] - CW'(1);
                    end
                end
                phase_cnt = ctb_pkg::CMP_W'(counts_next[ctb_pkg::PHASE_IDX]);
                phase_lim = ctb_pkg::CMP_W'(phase_limit_reg);
                if (phase_cnt > phase_lim) begin
                    counts_next[ctb_pkg::PHASE_IDX] = CW'(phase_limit_reg);
                end
            end
            ctb_pkg::CMD_SET: begin
                for (int i = 0; i < N; i++) begin
                    if (32'(in_sel_reg) == i) begin
                        counts_next[i] = CW'(in_load_reg);
                        flags_next[i]  = (i == ctb_pkg::DISPLAY_IDX);
                    end
                end
            end
            ctb_pkg::CMD_CLEAR: begin
                for (int i = 0; i < N; i++) begin
                    if (32'(in_sel_reg) == i) begin
                        flags_next[i] = 1'b0;
                    end
                end
            end
            ctb_pkg::CMD_REARM: begin
                for (int i = 0; i < N; i++) begin
                    hit = (32'(in_sel_reg) == i) && flags_reg[i];
                    if (hit) begin
                        counts_next[i] = CW'(in_load_reg);
                        flags_next[i]  = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase

        for (int i = 0; i < ctb_pkg::OUT_TIMERS; i++) begin
            flags_out[i] = flags_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            flags_reg       <= '0;
            phase_limit_reg <= ctb_pkg::PHASE_LIMIT_RESET;
            for (int i = 0; i < N; i++) begin
                counts_reg[i] <= ctb_pkg::reset_count(i);
            end
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance && in_valid_reg) begin
                counts_reg <= counts_next;
                flags_reg  <= flags_next;
            end
            if (cfg_write) begin
                phase_limit_reg <= pwdata[ctb_pkg::LIMIT_W-1:0];
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_cmd_reg  <= ctb_pkg::cmd_t'(s_axis_tuser[ctb_pkg::CMD_W-1:0]);
            in_sel_reg  <= s_axis_tuser[ctb_pkg::CMD_W +: ctb_pkg::SEL_W];
            in_load_reg <= s_axis_tdata[ctb_pkg::LOAD_W-1:0];
        end
        if (advance && in_valid_reg) begin
            out_sel_flag_reg <= sel_flag;
            out_flags_reg    <= flags_out;
        end
    end

endmodule

// ----- rtl/ctb_checker.sv -----
// Port-level checker for countdown_timer_bank and the bind that attaches it.
// Depends on ctb_pkg for the port widths.
module ctb_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [ctb_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result keeps its transaction in place.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // With no result waiting, the command side never stalls.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("command stalled with empty output");

    // A result rising on an empty output comes from an accepted command.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a matching command");

endmodule

bind countdown_timer_bank ctb_checker u_ctb_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
